// File: design/assert_macros.svh
// assertion macros shared by the detector modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication checked on every clock edge outside reset
`define KLPRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("klprd assertion failed");

// next-cycle implication checked on every clock edge outside reset
`define KLPRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("klprd assertion failed");

`endif

// File: design/klprd_pkg.sv
// shared types, codes and key encoder for the long press detector
package klprd_pkg;

    localparam logic [1:0] KEY_NONE = 2'd0;
    localparam logic [1:0] KEY_X    = 2'd1;
    localparam logic [1:0] KEY_Y    = 2'd2;
    localparam logic [1:0] KEY_K    = 2'd3;

    localparam logic [7:0] LONG_THRESHOLD_RESET   = 8'd200;
    localparam logic [7:0] REPEAT_THRESHOLD_RESET = 8'd20;

    localparam logic CFG_LONG_THRESHOLD   = 1'b0;
    localparam logic CFG_REPEAT_THRESHOLD = 1'b1;

    typedef struct packed {
        logic       short_press;
        logic       long_press;
        logic       auto_repeat;
        logic [1:0] held_key;
    } result_t;

    typedef struct packed {
        logic [7:0] long_threshold;
        logic [7:0] repeat_threshold;
    } thresholds_t;

    function automatic logic [1:0] encode_key(input logic x_n, input logic y_n,
                                              input logic k_n);
        logic [1:0] key;
        if (!x_n)
        begin
            key = KEY_X;
        end
        else if (!y_n)
        begin
            key = KEY_Y;
        end
        else if (!k_n)
        begin
            key = KEY_K;
        end
        else
        begin
            key = KEY_NONE;
        end
        return key;
    endfunction

endpackage

// File: design/klprd_core.sv
// press phase machine, hold counter and latched key, one tick per step
`include "assert_macros.svh"

module klprd_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   line_x_n,
    input  logic                   line_y_n,
    input  logic                   line_k_n,
    input  klprd_pkg::thresholds_t thresholds,
    output klprd_pkg::result_t     result_next
);

    typedef enum logic [1:0] {
        PHASE_UP     = 2'd0,
        PHASE_DOWN   = 2'd1,
        PHASE_TIMING = 2'd2,
        PHASE_LONG   = 2'd3
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] hold_reg, hold_next;
    logic [1:0] key_reg, key_next;
    logic [1:0] key;
    logic       pressed;
    logic [7:0] hold_inc;

    assign key      = klprd_pkg::encode_key(line_x_n, line_y_n, line_k_n);
    assign pressed  = (key != klprd_pkg::KEY_NONE);
    assign hold_inc = hold_reg + 8'd1;

    always_comb
    begin
        phase_next              = phase_reg;
        hold_next               = hold_reg;
        key_next                = key_reg;
        result_next.short_press = 1'b0;
        result_next.long_press  = 1'b0;
        result_next.auto_repeat = 1'b0;
        case (phase_reg)
            PHASE_UP:
            begin
                if (pressed)
                begin
                    phase_next = PHASE_DOWN;
                end
            end
            PHASE_DOWN:
            begin
                if (pressed)
                begin
                    phase_next = PHASE_TIMING;
                    hold_next  = 8'd0;
                    key_next   = key;
                end
                else
                begin
                    phase_next = PHASE_UP;
                end
            end
            PHASE_TIMING:
            begin
                if (!pressed)
                begin
                    phase_next              = PHASE_UP;
                    result_next.short_press = 1'b1;
                end
                else if (hold_inc > thresholds.long_threshold)
                begin
                    phase_next             = PHASE_LONG;
                    hold_next              = 8'd0;
                    result_next.long_press = 1'b1;
                end
                else
                begin
                    hold_next = hold_inc;
                end
            end
            PHASE_LONG:
            begin
                if (!pressed)
                begin
                    phase_next = PHASE_UP;
                end
                else
                begin
                    result_next.long_press = 1'b1;
                    if (hold_inc > thresholds.repeat_threshold)
                    begin
                        hold_next               = 8'd0;
                        result_next.auto_repeat = 1'b1;
                    end
                    else
                    begin
                        hold_next = hold_inc;
                    end
                end
            end
            default:
            begin
                phase_next = PHASE_UP;
            end
        endcase
        result_next.held_key = key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_UP;
            hold_reg  <= 8'd0;
            key_reg   <= klprd_pkg::KEY_NONE;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            key_reg   <= key_next;
        end
    end

    `KLPRD_ASSERT_NEXT(a_short_goes_up, clk, rst_n, step && result_next.short_press,
                       phase_reg == PHASE_UP)
    `KLPRD_ASSERT_NEXT(a_long_stays_long, clk, rst_n, step && result_next.long_press,
                       phase_reg == PHASE_LONG)
    `KLPRD_ASSERT_NOW(a_repeat_in_long, clk, rst_n, result_next.auto_repeat,
                      phase_reg == PHASE_LONG)

endmodule

// File: design/key_long_press_repeat_detector.sv
// top level: three rocker lines in, short/long/auto-repeat flags and held key out
//
// usage:
//   input request: in_valid/in_ready with line_x_n, line_y_n, line_k_n (active low),
//   one request per sampling tick. output request: out_valid/out_ready with
//   short_press, long_press, auto_repeat and held_key, exactly one per input.
//   each accepted input's result is registered in the result or skid register.
//   throughput: one request per cycle while in_ready is high; the phase machine and
//   hold counter step on each accepted request; only the output stage limits the rate.
//   a two-entry output buffer (result register plus skid register) lets one
//   more request in while a result waits; in_ready drops only when both are
//   full, and results leave in order.
//   configuration: cfg_we writes cfg_data into register cfg_index
//   (0 long threshold, 1 repeat threshold); write only while idle.
//   reset: asynchronous, active low; phase up, counter and key cleared,
//   thresholds back to 200 and 20, output buffer empty.
`include "assert_macros.svh"

module key_long_press_repeat_detector (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       line_x_n,
    input  logic       line_y_n,
    input  logic       line_k_n,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       short_press,
    output logic       long_press,
    output logic       auto_repeat,
    output logic [1:0] held_key
);

    klprd_pkg::thresholds_t thresholds_reg;
    klprd_pkg::result_t     result_next;
    klprd_pkg::result_t     out_reg;
    klprd_pkg::result_t     skid_reg;
    logic                   out_valid_reg;
    logic                   skid_valid_reg;
    logic                   accept;
    logic                   take;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign take     = out_valid_reg && out_ready;

    // threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresholds_reg.long_threshold   <= klprd_pkg::LONG_THRESHOLD_RESET;
            thresholds_reg.repeat_threshold <= klprd_pkg::REPEAT_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                klprd_pkg::CFG_LONG_THRESHOLD:
                begin
                    thresholds_reg.long_threshold <= cfg_data;
                end
                klprd_pkg::CFG_REPEAT_THRESHOLD:
                begin
                    thresholds_reg.repeat_threshold <= cfg_data;
                end
                default:
                begin
                    thresholds_reg <= thresholds_reg;
                end
            endcase
        end
    end

    klprd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .line_x_n    (line_x_n),
        .line_y_n    (line_y_n),
        .line_k_n    (line_k_n),
        .thresholds  (thresholds_reg),
        .result_next (result_next)
    );

    // output buffer valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_reg <= result_next;
            end
            else
            begin
                skid_reg <= result_next;
            end
        end
        else if (take && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign short_press = out_reg.short_press;
    assign long_press  = out_reg.long_press;
    assign auto_repeat = out_reg.auto_repeat;
    assign held_key    = out_reg.held_key;

    `KLPRD_ASSERT_NOW(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `KLPRD_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, accept && out_valid_reg && !out_ready,
                       skid_valid_reg)
    `KLPRD_ASSERT_NEXT(a_accept_gives_out, clk, rst_n, accept, out_valid_reg)

endmodule
